// ===== design/gtm_pkg.sv =====
`default_nettype none
package gtm_pkg;

   localparam int LAT_W       = 29;
   localparam int LON_W       = 30;
   localparam int COORD_W     = 26;
   localparam int TILE_W      = 16;
   localparam int WORD_W      = 64;
   localparam int FRAC_W      = 56;
   localparam int EXP_W       = 8;
   localparam int SERIES_TERMS = 28;
   localparam int LOG_ROUNDS  = 56;

   localparam logic signed [LAT_W-1:0] LAT_LIMIT = 29'sd85051128;
   localparam logic signed [LON_W-1:0] LON_LIMIT = 30'sd180000000;
   localparam logic [44:0]  KX_Q48       = 45'd31333651078479;
   localparam logic [37:0]  HALF_RAD_Q64 = 38'd160978210179;
   localparam logic [63:0]  LN2_Q64      = 64'hB17217F7D1CF79AC;
   localparam logic [22:0]  EARTH_R      = 23'd6378137;
   localparam logic [63:0]  ONE_Q62      = 64'h4000_0000_0000_0000;

   // term kinds of the sine/cosine series, by term index mod 4
   localparam logic [1:0] TERM_COS_ADD = 2'd0;
   localparam logic [1:0] TERM_SIN_ADD = 2'd1;
   localparam logic [1:0] TERM_COS_SUB = 2'd2;
   localparam logic [1:0] TERM_SIN_SUB = 2'd3;

   typedef struct packed {
      logic                      valid;
      logic                      ok;
      logic                      lat_neg;
      logic signed [COORD_W-1:0] east;
   } side_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] c;
   } ser_type;

   typedef struct packed {
      logic [WORD_W-1:0]       m;
      logic [FRAC_W-1:0]       frac;
      logic signed [EXP_W-1:0] e;
   } lane_type;

   typedef struct packed {
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } pp_type;

   typedef struct packed {
      logic                      fix_ok;
      logic signed [COORD_W-1:0] east;
      logic signed [COORD_W-1:0] north;
      logic signed [TILE_W-1:0]  col;
      logic signed [TILE_W-1:0]  row;
   } res_type;

   // 32x32 partial products of a 64x64 multiply
   function automatic pp_type mul_pp(input logic [63:0] a, input logic [63:0] b);
      pp_type r;
      r.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
      r.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
      r.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
      r.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
      return r;
   endfunction

   function automatic logic [127:0] pp_sum(input pp_type p);
      return {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0} + {p.p11, 64'd0};
   endfunction

   // Q62 product rounded half up
   function automatic logic [63:0] round_q62(input logic [127:0] x);
      logic [127:0] r;
      r = x + 128'h2000_0000_0000_0000;
      return r[125:62];
   endfunction

endpackage
`default_nettype wire

// ===== design/gtm_series_cell.sv =====
`default_nettype none
module gtm_series_cell #(
   parameter int K = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire gtm_pkg::side_type side_i,
   input  wire gtm_pkg::ser_type  ser_i,
   output gtm_pkg::side_type      side_o,
   output gtm_pkg::ser_type       ser_o
);
   import gtm_pkg::*;

   localparam logic [63:0] RCP  = 64'(64'h8000_0000_0000_0000 / 64'(K));
   localparam logic [63:0] KW   = 64'(K);
   localparam logic [1:0]  KIND = 2'(K % 4);

   side_type    sd_ff [0:5];
   ser_type     sr_ff [0:4];
   ser_type     out_ff;
   pp_type      pp1_ff, pp2_ff;
   logic [63:0] p_ff [1:3];
   logic [63:0] q0_ff, q_ff;

   logic [127:0] prod2;
   logic [63:0]  p_in, q0_in, rem_in, q_in;
   ser_type      acc_in;

   always_comb begin
      p_in   = round_q62(pp_sum(pp1_ff));
      prod2  = pp_sum(pp2_ff);
      q0_in  = prod2[126:63];
      rem_in = p_ff[3] - q0_ff * KW;
      q_in   = q0_ff + ((rem_in >= KW) ? 64'd1 : 64'd0);
      acc_in   = sr_ff[4];
      acc_in.t = q_ff;
      case (KIND)
         TERM_SIN_ADD: acc_in.s = sr_ff[4].s + q_ff;
         TERM_COS_SUB: acc_in.c = sr_ff[4].c - q_ff;
         TERM_SIN_SUB: acc_in.s = sr_ff[4].s - q_ff;
         default:      acc_in.c = sr_ff[4].c + q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) sd_ff[i] <= '0;
      end else if (en) begin
         sd_ff[0] <= side_i;
         for (int i = 1; i < 6; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= ser_i;
         pp1_ff   <= mul_pp(ser_i.t, ser_i.a);
         sr_ff[1] <= sr_ff[0];
         p_ff[1]  <= p_in;
         sr_ff[2] <= sr_ff[1];
         p_ff[2]  <= p_ff[1];
         pp2_ff   <= mul_pp(p_ff[1], RCP);
         sr_ff[3] <= sr_ff[2];
         p_ff[3]  <= p_ff[2];
         q0_ff    <= q0_in;
         sr_ff[4] <= sr_ff[3];
         q_ff     <= q_in;
         out_ff   <= acc_in;
      end
   end

   assign side_o = sd_ff[5];
   assign ser_o  = out_ff;

endmodule
`default_nettype wire

// ===== design/gtm_norm.sv =====
`default_nettype none
module gtm_norm (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire gtm_pkg::side_type      side_i,
   input  wire gtm_pkg::ser_type       ser_i,
   output gtm_pkg::side_type           side_o,
   output gtm_pkg::lane_type [1:0]     lane_o
);
   import gtm_pkg::*;

   side_type sd_ff [0:2];
   lane_type [1:0] w0_ff, w1_ff, w2_ff;
   lane_type [1:0] w0_in, w1_in, w2_in;

   function automatic lane_type step(input lane_type x, input int sh);
      lane_type r;
      r = x;
      if ((x.m[62:0] >> (63 - sh)) == 63'd0) begin
         r.m = x.m << sh;
         r.e = x.e + EXP_W'(sh);
      end
      return r;
   endfunction

   always_comb begin
      w0_in[0].m = ser_i.c + ser_i.s;
      w0_in[1].m = ser_i.c - ser_i.s;
      for (int i = 0; i < 2; i++) begin
         w0_in[i].frac = '0;
         w0_in[i].e    = '0;
         if (w0_ff[i].m[63]) begin
            w1_in[i]   = w0_ff[i];
            w1_in[i].m = w0_ff[i].m >> 1;
            w1_in[i].e = -8'sd1;
         end else begin
            w1_in[i] = step(step(step(w0_ff[i], 32), 16), 8);
         end
         w2_in[i] = step(step(step(w1_ff[i], 4), 2), 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) sd_ff[i] <= '0;
      end else if (en) begin
         sd_ff[0] <= side_i;
         sd_ff[1] <= sd_ff[0];
         sd_ff[2] <= sd_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
      end
   end

   assign side_o = sd_ff[2];
   assign lane_o = w2_ff;

endmodule
`default_nettype wire

// ===== design/gtm_log_cell.sv =====
`default_nettype none
module gtm_log_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire gtm_pkg::side_type      side_i,
   input  wire gtm_pkg::lane_type [1:0] lane_i,
   output gtm_pkg::side_type           side_o,
   output gtm_pkg::lane_type [1:0]     lane_o
);
   import gtm_pkg::*;

   side_type sd_ff [0:1];
   pp_type   pp_ff [0:1];
   lane_type [1:0] hold_ff, out_ff, out_in;
   logic [63:0] sq [0:1];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         sq[i]     = round_q62(pp_sum(pp_ff[i]));
         out_in[i] = hold_ff[i];
         if (sq[i][63]) begin
            out_in[i].m    = sq[i] >> 1;
            out_in[i].frac = {hold_ff[i].frac[FRAC_W-2:0], 1'b1};
         end else begin
            out_in[i].m    = sq[i];
            out_in[i].frac = {hold_ff[i].frac[FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff[0] <= '0;
         sd_ff[1] <= '0;
      end else if (en) begin
         sd_ff[0] <= side_i;
         sd_ff[1] <= sd_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 2; i++) pp_ff[i] <= mul_pp(lane_i[i].m, lane_i[i].m);
         hold_ff <= lane_i;
         out_ff  <= out_in;
      end
   end

   assign side_o = sd_ff[1];
   assign lane_o = out_ff;

endmodule
`default_nettype wire

// ===== design/gtm_tile_div.sv =====
`default_nettype none
module gtm_tile_div #(
   parameter int BLOCK_METERS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire gtm_pkg::side_type           side_i,
   input  wire logic signed [gtm_pkg::COORD_W-1:0] north_i,
   output logic                             valid_o,
   output gtm_pkg::res_type                 res_o
);
   import gtm_pkg::*;

   // floor(v/D) = (v + OFF) / D - OFF_Q, with OFF = OFF_Q * D keeping the dividend positive
   localparam int          OFF_Q_I = (2**25 + BLOCK_METERS - 1) / BLOCK_METERS;
   localparam logic [27:0] OFF_Q   = 28'(OFF_Q_I);
   localparam logic [26:0] OFF     = 27'(OFF_Q_I * BLOCK_METERS);
   localparam logic [16:0] DIV     = 17'(BLOCK_METERS);
   localparam logic [40:0] RCP     = 41'((64'd1 << 40) / 64'(BLOCK_METERS));

   side_type sd_ff [0:3];
   logic signed [COORD_W-1:0] nt_ff [0:3];
   logic [26:0] u_ff [0:1], u1_ff [0:1], u2_ff [0:1];
   logic [58:0] pl_ff [0:1];
   logic [35:0] ph_ff [0:1];
   logic [27:0] q0_ff [0:1];
   logic signed [TILE_W-1:0] tile_ff [0:1];

   logic [COORD_W-1:0] v [0:1];
   logic [26:0] u_in [0:1];
   logic [67:0] sum [0:1];
   logic [44:0] rem [0:1];
   logic [27:0] q [0:1];

   always_comb begin
      v[0] = side_i.east;
      v[1] = north_i;
      for (int i = 0; i < 2; i++) begin
         u_in[i] = {v[i][COORD_W-1], v[i]} + OFF;
         sum[i]  = 68'(pl_ff[i]) + {ph_ff[i], 32'd0};
         rem[i]  = 45'(u2_ff[i]) - 45'(q0_ff[i]) * 45'(DIV);
         q[i]    = q0_ff[i] + ((rem[i] >= 45'(DIV)) ? 28'd1 : 28'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) sd_ff[i] <= '0;
      end else if (en) begin
         sd_ff[0] <= side_i;
         for (int i = 1; i < 4; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nt_ff[0] <= north_i;
         for (int i = 1; i < 4; i++) nt_ff[i] <= nt_ff[i-1];
         for (int i = 0; i < 2; i++) begin
            u_ff[i]    <= u_in[i];
            pl_ff[i]   <= 59'(u_ff[i]) * 59'(RCP[31:0]);
            ph_ff[i]   <= 36'(u_ff[i]) * 36'(RCP[40:32]);
            u1_ff[i]   <= u_ff[i];
            q0_ff[i]   <= sum[i][67:40];
            u2_ff[i]   <= u1_ff[i];
            tile_ff[i] <= TILE_W'(q[i] - OFF_Q);
         end
      end
   end

   assign valid_o      = sd_ff[3].valid;
   assign res_o.fix_ok = sd_ff[3].ok;
   assign res_o.east   = sd_ff[3].east;
   assign res_o.north  = nt_ff[3];
   assign res_o.col    = tile_ff[0];
   assign res_o.row    = tile_ff[1];

endmodule
`default_nettype wire

// ===== design/gps_to_mercator_block.sv =====
// Channel  | Ports              | Payload (lowest bit first)
// ---------+--------------------+-----------------------------------------------------
// request  | req_t{valid,ready} | tdata: latitude_micro[28:0], longitude_micro[58:29]
// response | rsp_t{valid,ready} | tdata: east, north, tile_col, tile_row; tuser: fix_ok
//
// One item enters per cycle while the output buffer has room. The pipe is the
// cell chain: 3 front stages, 28 series cells of 6 stages,
// 3 normaliser stages, 56 log cells of 2 stages, 5 back stages and 4 tile stages.
// Reset clears all stage valid bits and the output buffer.
// A 2-item output buffer lets the pipe keep taking items while a result waits;
// the whole pipe holds only when both entries are full.
`default_nettype none
module gps_to_mercator_block #(
   parameter int BLOCK_METERS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // latitude_micro[28:0], longitude_micro[58:29]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // east[25:0], north[51:26], col[67:52], row[83:68]
   output logic [0:0]       rsp_tuser    // fix_ok[0]
);
   import gtm_pkg::*;

   logic en;

   // ---------------- front: range test, X, series argument ----------------
   logic signed [LAT_W-1:0] lat_in;
   logic signed [LON_W-1:0] lon_in;
   logic                    ok_in;
   side_type                side_in;

   side_type         fs0_ff, fs1_ff, fs2_ff;
   logic [LAT_W-1:0] lat_mag_ff;
   logic [LON_W-1:0] lon_mag_ff;
   logic             lon_neg_ff, lon_neg1_ff;
   logic [61:0]      x_lo_ff;
   logic [42:0]      x_hi_ff;
   logic [60:0]      a_lo_ff;
   logic [34:0]      a_hi_ff;
   ser_type          ser0_ff;

   logic [75:0]         x_sum;
   logic [COORD_W-1:0]  xm;
   logic [66:0]         a_sum;
   side_type            fs2_in;
   ser_type             ser0_in;

   assign lat_in = req_tdata[LAT_W-1:0];
   assign lon_in = req_tdata[LAT_W+LON_W-1:LAT_W];
   assign ok_in  = !(lat_in == '0 && lon_in == '0) &&
                   lat_in >= -LAT_LIMIT && lat_in <= LAT_LIMIT &&
                   lon_in >= -LON_LIMIT && lon_in <= LON_LIMIT;

   always_comb begin
      side_in.valid   = req_tvalid;
      side_in.ok      = ok_in;
      side_in.lat_neg = lat_in[LAT_W-1];
      side_in.east    = '0;

      x_sum = 76'(x_lo_ff) + 76'({x_hi_ff, 32'd0}) + 76'h8000_0000_0000;
      xm    = x_sum[73:48];
      fs2_in = fs1_ff;
      if (!fs1_ff.ok)       fs2_in.east = '0;
      else if (lon_neg1_ff) fs2_in.east = -$signed(xm);
      else                  fs2_in.east = $signed(xm);

      a_sum     = 67'(a_lo_ff) + {a_hi_ff, 32'd0} + 67'd2;
      ser0_in.a = {2'b00, a_sum[63:2]};
      ser0_in.t = ONE_Q62;
      ser0_in.s = '0;
      ser0_in.c = ONE_Q62;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs0_ff <= '0;
         fs1_ff <= '0;
         fs2_ff <= '0;
      end else if (en) begin
         fs0_ff <= side_in;
         fs1_ff <= fs0_ff;
         fs2_ff <= fs2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lat_mag_ff  <= lat_in[LAT_W-1] ? LAT_W'(-lat_in) : LAT_W'(lat_in);
         lon_mag_ff  <= lon_in[LON_W-1] ? LON_W'(-lon_in) : LON_W'(lon_in);
         lon_neg_ff  <= lon_in[LON_W-1];
         lon_neg1_ff <= lon_neg_ff;
         x_lo_ff     <= 62'(lon_mag_ff) * 62'(KX_Q48[31:0]);
         x_hi_ff     <= 43'(lon_mag_ff) * 43'(KX_Q48[44:32]);
         a_lo_ff     <= 61'(lat_mag_ff) * 61'(HALF_RAD_Q64[31:0]);
         a_hi_ff     <= 35'(lat_mag_ff) * 35'(HALF_RAD_Q64[37:32]);
         ser0_ff     <= ser0_in;
      end
   end

   // ---------------- sine/cosine series: one cell per term ----------------
   side_type ser_sd [0:SERIES_TERMS];
   ser_type  ser_d  [0:SERIES_TERMS];

   assign ser_sd[0] = fs2_ff;
   assign ser_d[0]  = ser0_ff;

   for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_series
      gtm_series_cell #(.K(g + 1)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .side_i (ser_sd[g]),
         .ser_i  (ser_d[g]),
         .side_o (ser_sd[g+1]),
         .ser_o  (ser_d[g+1])
      );
   end

   // ---------------- log2 of cos+sin and cos-sin ----------------
   side_type       lg_sd [0:LOG_ROUNDS];
   lane_type [1:0] lg_ln [0:LOG_ROUNDS];

   gtm_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .side_i (ser_sd[SERIES_TERMS]),
      .ser_i  (ser_d[SERIES_TERMS]),
      .side_o (lg_sd[0]),
      .lane_o (lg_ln[0])
   );

   for (genvar g = 0; g < LOG_ROUNDS; g++) begin : g_log
      gtm_log_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .side_i (lg_sd[g]),
         .lane_i (lg_ln[g]),
         .side_o (lg_sd[g+1]),
         .lane_o (lg_ln[g+1])
      );
   end

   // ---------------- back: difference, times ln 2, times R ----------------
   lane_type [1:0] lf;
   logic [63:0] la, lb, dif;
   logic [127:0] ln_prod;
   logic [86:0]  y_sum;
   logic [COORD_W-1:0] ym;
   logic signed [COORD_W-1:0] north_in;

   side_type    bs_ff [0:4];
   logic [63:0] d_ff, mln_ff;
   pp_type      ln_pp_ff;
   logic [54:0] pr_lo_ff, pr_hi_ff;
   logic signed [COORD_W-1:0] north_ff;

   always_comb begin
      lf  = lg_ln[LOG_ROUNDS];
      la  = {8'd0, lf[0].frac} - {lf[0].e, 56'd0};
      lb  = {8'd0, lf[1].frac} - {lf[1].e, 56'd0};
      dif = la - lb;
      ln_prod = pp_sum(ln_pp_ff);
      y_sum = 87'(pr_lo_ff) + {pr_hi_ff, 32'd0} + 87'h80_0000_0000_0000;
      ym    = y_sum[81:56];
      if (!bs_ff[3].ok)        north_in = '0;
      else if (bs_ff[3].lat_neg) north_in = -$signed(ym);
      else                     north_in = $signed(ym);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) bs_ff[i] <= '0;
      end else if (en) begin
         bs_ff[0] <= lg_sd[LOG_ROUNDS];
         for (int i = 1; i < 5; i++) bs_ff[i] <= bs_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= dif[63] ? 64'd0 : dif;       // negative difference clamps to zero
         ln_pp_ff <= mul_pp(d_ff, LN2_Q64);
         mln_ff   <= ln_prod[127:64] + 64'(ln_prod[63]);
         pr_lo_ff <= 55'(mln_ff[31:0])  * 55'(EARTH_R);
         pr_hi_ff <= 55'(mln_ff[63:32]) * 55'(EARTH_R);
         north_ff <= north_in;
      end
   end

   // ---------------- block coordinates ----------------
   logic    tile_valid;
   res_type tile_res;

   gtm_tile_div #(.BLOCK_METERS(BLOCK_METERS)) u_tile (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .side_i  (bs_ff[4]),
      .north_i (north_ff),
      .valid_o (tile_valid),
      .res_o   (tile_res)
   );

   // ---------------- output buffer, two items ----------------
   res_type    head_ff, spare_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign en   = (count_ff != 2'd2);
   assign push = en && tile_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) head_ff <= spare_ff;
         else if (push)        head_ff <= tile_res;
      end else if (push) begin
         if (count_ff == 2'd0) head_ff <= tile_res;
      end
      if (push && ((count_ff == 2'd1 && !pop) || count_ff == 2'd2)) spare_ff <= tile_res;
   end

   assign req_tready   = en;
   assign rsp_tvalid   = (count_ff != 2'd0);
   assign rsp_tdata    = {4'd0, head_ff.row, head_ff.col, head_ff.north, head_ff.east};
   assign rsp_tuser[0] = head_ff.fix_ok;

endmodule
`default_nettype wire

// ===== design/gtm_checker.sv =====
`default_nettype none
module gtm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [87:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held result changed");

   // a rejected fix carries all-zero coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 88'd0)
      else $error("rejected fix with nonzero data");

   // the input side only stalls when results are waiting
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // nothing is shown straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

endmodule

bind gps_to_mercator_block gtm_checker u_gtm_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gtm_pkg::*;

   localparam int BLOCK_M     = 1024;
   localparam int CYCLE_LIMIT = 300000;  // slowest legal run is well under this
   localparam int DRAIN_WAIT  = 400;     // settle time after the queue drains

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;          // latitude_micro[28:0], longitude_micro[58:29]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;               // east[25:0], north[51:26], col[67:52], row[83:68]
   logic [0:0]  rsp_tuser;               // fix_ok[0]

   res_type fix_queue[$];                // projections still owed by the block
   int      n_errors = 0;
   int      n_cycles = 0;
   int      burst_left = 0;

   gps_to_mercator_block #(.BLOCK_METERS(BLOCK_M)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   // Q62 product, rounded half up
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << 61);
      return p[125:62];
   endfunction

   // log2 of unsigned Q62 as signed Q56
   function automatic longint log2_fix(input logic [63:0] x);
      logic [63:0] m;
      logic [63:0] frac;
      longint      e;
      m = x;
      frac = '0;
      e = 0;
      if (m == 0) return 0;
      while (m < ONE_Q62) begin
         m = m << 1;
         e++;
      end
      while (m >= 64'h8000_0000_0000_0000) begin
         m = m >> 1;
         e--;
      end
      for (int i = 0; i < 56; i++) begin
         m = q62_mul(m, m);
         frac = frac << 1;
         if (m >= 64'h8000_0000_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return longint'(frac) - e * (longint'(1) << 56);
   endfunction

   function automatic longint east_of(input longint lon);
      logic [127:0] p;
      logic [63:0]  mag;
      mag = (lon < 0) ? -lon : lon;
      p = {64'd0, mag} * {83'd0, KX_Q48};
      p = p + (128'd1 << 47);
      return (lon < 0) ? -longint'(p[111:48]) : longint'(p[111:48]);
   endfunction

   function automatic longint north_of(input longint lat);
      logic [63:0]  mag, a, t, s, c, m;
      logic [127:0] p;
      longint       d;
      mag = (lat < 0) ? -lat : lat;
      a = (mag * {26'd0, HALF_RAD_Q64} + 64'd2) >> 2;
      t = ONE_Q62;
      s = '0;
      c = ONE_Q62;
      for (int k = 1; k <= 28; k++) begin
         t = q62_mul(t, a) / k;
         case (k % 4)
            1: s = s + t;
            2: c = c - t;
            3: s = s - t;
            default: c = c + t;
         endcase
      end
      d = log2_fix(c + s) - log2_fix(c - s);
      if (d < 0) d = 0;
      p = {64'd0, 64'(d)} * {64'd0, LN2_Q64};
      m = p[127:64] + p[63];
      p = {64'd0, m} * {105'd0, EARTH_R};
      p = p + (128'd1 << 55);
      return (lat < 0) ? -longint'(p[119:56]) : longint'(p[119:56]);
   endfunction

   function automatic longint tile_of(input longint v);
      longint q, r;
      q = v / BLOCK_M;
      r = v % BLOCK_M;
      if (r != 0 && (r < 0)) q--;
      return q;
   endfunction

   function automatic res_type project_fix(input logic [28:0] lat_bits,
                                           input logic [29:0] lon_bits);
      res_type r;
      longint  lat, lon, x, y;
      lat = longint'($signed(lat_bits));
      lon = longint'($signed(lon_bits));
      x = 0;
      y = 0;
      r.fix_ok = !(lat == 0 && lon == 0) && lat >= -85051128 && lat <= 85051128 &&
                 lon >= -180000000 && lon <= 180000000;
      if (r.fix_ok) begin
         x = east_of(lon);
         y = north_of(lat);
      end
      r.east  = x[COORD_W-1:0];
      r.north = y[COORD_W-1:0];
      r.col   = 16'(tile_of(x));
      r.row   = 16'(tile_of(y));
      return r;
   endfunction

   // ---------------------------------------------------------------- sender
   // Holds valid across back-to-back items inside a burst; gaps between bursts.
   task automatic send_fix(input logic [28:0] lat, input logic [29:0] lon);
      int gap;
      req_tdata  <= {5'd0, lon, lat};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      fix_queue.push_back(project_fix(lat, lon));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   // Drives ready high when the phase counter is even and above 100, and random otherwise.
   int stall_phase = 0;
   always @(posedge clock) begin
      if (stall_phase == 0) stall_phase <= $urandom_range(20, 200);
      else stall_phase <= stall_phase - 1;
      if (stall_phase % 2 == 0 && stall_phase > 100) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // ---------------------------------------------------------------- checker
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      n_errors++;
   endtask

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fix_queue.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = fix_queue.pop_front();
            if (rsp_tuser[0] !== want.fix_ok)
               report_mismatch("fix_ok", rsp_tuser[0], want.fix_ok);
            if (rsp_tdata[25:0] !== want.east)
               report_mismatch("east", $signed(rsp_tdata[25:0]), want.east);
            if (rsp_tdata[51:26] !== want.north)
               report_mismatch("north", $signed(rsp_tdata[51:26]), want.north);
            if (rsp_tdata[67:52] !== want.col)
               report_mismatch("tile_col", $signed(rsp_tdata[67:52]), want.col);
            if (rsp_tdata[83:68] !== want.row)
               report_mismatch("tile_row", $signed(rsp_tdata[83:68]), want.row);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // edges of the range test, zero fix, raw bit extremes
   task automatic test_directed();
      send_fix(29'd0, 30'd0);                       // both zero: rejected
      send_fix(29'd1, 30'd0);
      send_fix(29'd0, 30'd1);
      send_fix(29'h1FFF_FFFF, 30'h3FFF_FFFF);       // -1, -1
      send_fix(29'sd85051128, 30'sd180000000);
      send_fix(-29'sd85051128, -30'sd180000000);
      send_fix(29'sd85051129, 30'd5);               // just past latitude limit
      send_fix(-29'sd85051129, 30'd5);
      send_fix(29'd5, 30'sd180000001);              // just past longitude limit
      send_fix(29'd5, -30'sd180000001);
      send_fix(29'h0FFF_FFFF, 30'h1FFF_FFFF);       // most positive patterns
      send_fix(29'h1000_0000, 30'h2000_0000);       // most negative patterns
      send_fix(29'sd180000000, -30'sd360000000);
      send_fix(-29'sd180000000, 30'sd360000000);
      send_fix(29'sd45000000, 30'sd90000000);
      send_fix(-29'sd45000000, -30'sd90000000);
      send_fix(29'sd1000, 30'sd1000);               // near the origin, tiny tiles
      send_fix(-29'sd1000, -30'sd1000);
      send_fix(29'sd85000000, -30'sd1);
   endtask

   task automatic test_random(input int n_items);
      logic [28:0] lat;
      logic [29:0] lon;
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(0, 9))
            0: begin                                // raw bit patterns, mostly rejected
               lat = 29'($urandom);
               lon = 30'($urandom);
            end
            1: begin                                // hug the limits
               lat = 29'($urandom_range(85051120, 85051135));
               lon = 30'($urandom_range(179999990, 180000010));
               if ($urandom_range(0, 1)) lat = -lat;
               if ($urandom_range(0, 1)) lon = -lon;
            end
            2: begin                                // within the stated field range
               lat = 29'($signed($urandom_range(0, 360000000)) - 180000000);
               lon = 30'($signed($urandom_range(0, 720000000)) - 360000000);
            end
            default: begin                          // valid fix anywhere on the map
               lat = 29'($signed($urandom_range(0, 170102256)) - 85051128);
               lon = 30'($signed($urandom_range(0, 360000000)) - 180000000);
            end
         endcase
         send_fix(lat, lon);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1030);
      req_tvalid <= 1'b0;
      while (fix_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
